[rtl/core/brc_pkg.sv]
// shared constants and register index codes for the blit rectangle clipper
`default_nettype none
package brc_pkg;

  localparam int REG_W = 15;

  typedef enum logic [1:0] {
    REG_X_OFF  = 2'd0,
    REG_Y_OFF  = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_idx_t;

endpackage
`default_nettype wire

[rtl/core/blit_rect_clip_scale.sv]
// blit rectangle clipper: window hit test, source clip, pipelined destination scaling
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | s_tdata: 8 signed coords (src then dst)
//  m_*      | out | m_tvalid/m_tready  | m_tdata: 8 signed coords, m_tuser: hit
//  apb      | in  | psel/penable/pready| window offset and size registers
//
// one transaction per cycle sustained while m_tready is high; the pipeline depth is set by the
// restoring divider cut into DPS quotient bits per stage (four lanes side by side)
// rst is synchronous active high and clears valid bits and window registers
// a stalled output holds every stage in place, so nothing is dropped or repeated
`default_nettype none
module blit_rect_clip_scale #(
  parameter int COORD_WIDTH = 16
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      s_tvalid,
  output logic                     s_tready,
  // src_left, src_top, src_right, src_bottom, dst_left, dst_top, dst_right, dst_bottom
  input  wire  [8*COORD_WIDTH-1:0] s_tdata,
  output logic                     m_tvalid,
  input  wire                      m_tready,
  // out_src_left, out_src_top, out_src_right, out_src_bottom,
  // out_dst_left, out_dst_top, out_dst_right, out_dst_bottom
  output logic [8*COORD_WIDTH-1:0] m_tdata,
  // hit
  output logic                     m_tuser,
  input  wire                      psel,
  input  wire                      penable,
  input  wire                      pwrite,
  input  wire  [3:0]               paddr,
  input  wire  [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import brc_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int XW   = ((CW > 16) ? CW : 16) + 3;  // room for off + len and edge math
  localparam int MW   = CW + 1;                     // span and dest width magnitudes
  localparam int PW   = XW + MW;                    // product width
  localparam int DPS  = 4;                          // quotient bits per divider stage
  localparam int NDIV = (PW + DPS - 1) / DPS;
  localparam int QW   = NDIV * DPS;
  localparam int RW   = QW + 3;
  localparam int NST  = NDIV + 4;
  localparam int TDW  = 8 * CW;

  // window registers
  logic [REG_W-1:0] win [4];
  reg_idx_t         widx;

  assign widx   = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign prdata = {{(32-REG_W){1'b0}}, win[widx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) win[i] <= '0;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_X_OFF:  win[0] <= pwdata[REG_W-1:0];
        REG_Y_OFF:  win[1] <= pwdata[REG_W-1:0];
        REG_WIDTH:  win[2] <= pwdata[REG_W-1:0];
        REG_HEIGHT: win[3] <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [CW-1:0] sat(input logic signed [RW-1:0] x);
    logic signed [RW-1:0] hi;
    logic signed [RW-1:0] lo;
    hi = {{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    lo = ~hi;
    if (x > hi) return hi[CW-1:0];
    if (x < lo) return lo[CW-1:0];
    return x[CW-1:0];
  endfunction

  function automatic logic signed [RW-1:0] sx(input logic signed [XW-1:0] x);
    return {{(RW-XW){x[XW-1]}}, x};
  endfunction

  // round(d + q + r/c) half away from zero, sign applied, then clamp
  function automatic logic signed [CW-1:0] round_sat(input logic ng,
      input logic signed [CW-1:0] d, input logic [QW-1:0] q,
      input logic [MW-1:0] r, input logic [MW-1:0] c);
    logic signed [RW-1:0] de;
    logic signed [RW-1:0] qe;
    logic signed [RW-1:0] x;
    logic signed [RW-1:0] rnd;
    logic [MW:0]          r2;
    logic                 up;
    de = {{(RW-CW){d[CW-1]}}, d};
    qe = {3'b000, q};
    x  = ng ? (qe - de) : (de + qe);
    r2 = {r, 1'b0};
    if (x > 0 || (x == 0 && r != '0)) up = (r2 >= {1'b0, c});
    else up = (r2 > {1'b0, c});
    rnd = x + {{(RW-1){1'b0}}, up};
    return sat(ng ? -rnd : rnd);
  endfunction

  // pipeline control: every stage advances together
  logic [NST-1:0] vld;
  logic           en;

  assign en       = !vld[NST-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[NST-2:0], s_tvalid};
  end

  // payload and hit flag carried along every stage
  logic [TDW-1:0] pay [NST];
  logic           hit_p [NST];

  // stage 0: hit test and source clip per axis
  logic              hit_a   [2];
  logic [CW-1:0]     snear_a [2];
  logic [CW-1:0]     sfar_a  [2];
  logic signed [XW-1:0] dw_c [2];
  logic signed [XW-1:0] b_c  [2];
  logic signed [XW-1:0] w_c  [2];
  logic signed [XW-1:0] sp_c [2];

  logic signed [XW-1:0] dw0 [2];
  logic signed [XW-1:0] b0  [2];
  logic signed [XW-1:0] w0  [2];
  logic signed [XW-1:0] sp0 [2];
  logic signed [CW-1:0] d10 [2];

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis0
    logic signed [XW-1:0] s1, s2, d1, d2, off, far_win, v, e;
    always_comb begin
      s1      = {{(XW-CW){s_tdata[ax*CW+CW-1]}}, s_tdata[ax*CW +: CW]};
      s2      = {{(XW-CW){s_tdata[(2+ax)*CW+CW-1]}}, s_tdata[(2+ax)*CW +: CW]};
      d1      = {{(XW-CW){s_tdata[(4+ax)*CW+CW-1]}}, s_tdata[(4+ax)*CW +: CW]};
      d2      = {{(XW-CW){s_tdata[(6+ax)*CW+CW-1]}}, s_tdata[(6+ax)*CW +: CW]};
      off     = {{(XW-REG_W){1'b0}}, win[ax]};
      far_win = off + {{(XW-REG_W){1'b0}}, win[2+ax]};
      v       = (s1 > off) ? s1 : off;
      e       = (s2 < far_win) ? s2 : far_win;
      hit_a[ax]   = (s2 >= off) && (s1 < far_win);
      snear_a[ax] = sat(sx(v - off));
      sfar_a[ax]  = sat(sx(e - off));
      dw_c[ax]    = d2 - d1;
      b_c[ax]     = v - s1;
      w_c[ax]     = e - v;
      sp_c[ax]    = s2 - s1;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dw0[ax] <= dw_c[ax];
        b0[ax]  <= b_c[ax];
        w0[ax]  <= w_c[ax];
        sp0[ax] <= sp_c[ax];
        d10[ax] <= s_tdata[(4+ax)*CW +: CW];
      end
    end
  end

  logic           hit_c;
  logic [TDW-1:0] pay_c;

  always_comb begin
    hit_c = hit_a[0] && hit_a[1];
    pay_c = s_tdata;
    if (hit_c) begin
      for (int ax = 0; ax < 2; ax++) begin
        pay_c[ax*CW +: CW]     = snear_a[ax];
        pay_c[(2+ax)*CW +: CW] = sfar_a[ax];
      end
    end
  end

  // divider lanes: lane 2*ax is the near edge, 2*ax+1 the far edge
  logic [QW-1:0]        qd  [4][NDIV+1];
  logic [MW-1:0]        rm  [4][NDIV+1];
  logic                 ng  [4][NDIV+1];
  logic [MW-1:0]        mcq [2][NDIV+1];
  logic signed [CW-1:0] dd  [2][NDIV+1];

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis1
    logic [XW-1:0] spa;
    logic          zero;
    assign spa  = sp0[ax][XW-1] ? (~sp0[ax] + 1'b1) : sp0[ax];
    assign zero = (sp0[ax] == '0);

    always_ff @(posedge clk) begin
      if (en) begin
        mcq[ax][0] <= zero ? {{(MW-1){1'b0}}, 1'b1} : spa[MW-1:0];
        dd[ax][0]  <= d10[ax];
        for (int j = 1; j <= NDIV; j++) begin
          mcq[ax][j] <= mcq[ax][j-1];
          dd[ax][j]  <= dd[ax][j-1];
        end
      end
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    localparam int AX = l / 2;
    localparam int FAR = l % 2;
    logic signed [XW-1:0] bsel;
    logic [XW-1:0]        ma, mb;
    logic [PW-1:0]        prod;

    assign bsel = (FAR != 0) ? w0[AX] : b0[AX];
    assign ma   = dw0[AX][XW-1] ? (~dw0[AX] + 1'b1) : dw0[AX];
    assign mb   = bsel[XW-1] ? (~bsel + 1'b1) : bsel;
    assign prod = ma[MW-1:0] * mb;

    always_ff @(posedge clk) begin
      if (en) begin
        qd[l][0] <= (sp0[AX] == '0) ? '0 : QW'(prod);
        rm[l][0] <= '0;
        ng[l][0] <= dw0[AX][XW-1] ^ bsel[XW-1] ^ sp0[AX][XW-1];
      end
    end

    for (genvar j = 0; j < NDIV; j++) begin : g_step
      logic [QW-1:0] qn;
      logic [MW:0]   rn;
      always_comb begin
        qn = qd[l][j];
        rn = {1'b0, rm[l][j]};
        for (int b = 0; b < DPS; b++) begin
          rn = {rn[MW-1:0], qn[QW-1]};
          qn = {qn[QW-2:0], 1'b0};
          if (rn >= {1'b0, mcq[AX][j]}) begin
            rn    = rn - {1'b0, mcq[AX][j]};
            qn[0] = 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          qd[l][j+1] <= qn;
          rm[l][j+1] <= rn[MW-1:0];
          ng[l][j+1] <= ng[l][j];
        end
      end
    end
  end

  // near edge round stage, far lane operands held alongside
  logic signed [CW-1:0] nd1 [2];
  logic [QW-1:0]        qf  [2];
  logic [MW-1:0]        rf  [2];
  logic [MW-1:0]        cf  [2];
  logic                 nf  [2];
  logic [TDW-1:0]       pay_r1, pay_r2;

  always_comb begin
    pay_r1 = pay[NST-3];
    for (int ax = 0; ax < 2; ax++) begin
      if (hit_p[NST-3]) begin
        pay_r1[(4+ax)*CW +: CW] = round_sat(ng[2*ax][NDIV], dd[ax][NDIV],
                                            qd[2*ax][NDIV], rm[2*ax][NDIV], mcq[ax][NDIV]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int ax = 0; ax < 2; ax++) begin
        nd1[ax] <= pay_r1[(4+ax)*CW +: CW];
        qf[ax]  <= qd[2*ax+1][NDIV];
        rf[ax]  <= rm[2*ax+1][NDIV];
        cf[ax]  <= mcq[ax][NDIV];
        nf[ax]  <= ng[2*ax+1][NDIV];
      end
    end
  end

  // far edge from the clamped near edge
  always_comb begin
    pay_r2 = pay[NST-2];
    for (int ax = 0; ax < 2; ax++) begin
      if (hit_p[NST-2]) begin
        pay_r2[(6+ax)*CW +: CW] = round_sat(nf[ax], nd1[ax], qf[ax], rf[ax], cf[ax]);
      end
    end
  end

  // payload shift chain, with the two rounding stages at its end
  always_ff @(posedge clk) begin
    if (en) begin
      pay[0]   <= pay_c;
      hit_p[0] <= hit_c;
      for (int i = 1; i < NST - 2; i++) begin
        pay[i]   <= pay[i-1];
        hit_p[i] <= hit_p[i-1];
      end
      pay[NST-2]   <= pay_r1;
      hit_p[NST-2] <= hit_p[NST-3];
      pay[NST-1]   <= pay_r2;
      hit_p[NST-1] <= hit_p[NST-2];
    end
  end

  assign m_tdata = pay[NST-1];
  assign m_tuser = hit_p[NST-1];

  // reset empties the whole pipeline
  a_rst_empty: assert property (@(posedge clk) rst |=> vld == '0)
    else $error("pipeline not empty after reset");

  // a stall freezes the valid pattern across all stages
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(vld))
    else $error("valid bits moved during stall");

  // an item seen at the output came from the stage before it
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid) && !$past(rst)) |-> $past(vld[NST-2]))
    else $error("output valid without an item behind it");

endmodule
`default_nettype wire
